### rtl/cbt_pkg.sv
// cbt_pkg: types and constants for the camera bearing to target block.
// Holds the CORDIC arctangent table, angle constants and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

    // angle accumulator: degrees * 2^16, signed
    localparam int ZW = 26;
    localparam int TAB_DEPTH = 24;

    localparam int HEAD_W = 18;
    localparam int FOV_W  = 17;
    localparam int REL_W  = 19;
    localparam int BRG_W  = ZW - 8;
    localparam int SUM_W  = REL_W + 1;

    typedef logic signed [ZW-1:0] t_angle;
    typedef logic [1:0]           t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_AT_CAM  = 2'd1;
    localparam t_status ST_BELOW   = 2'd2;
    localparam t_status ST_ABOVE   = 2'd3;

    localparam t_angle HALF_TURN = 26'sd11796480;
    localparam t_angle ROUND_BIAS = 26'sd128;
    localparam logic signed [SUM_W-1:0] RIGHT_ANGLE_Q8 = 20'sd23040;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    localparam t_angle ATAN_TAB [0:TAB_DEPTH-1] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

endpackage

`default_nettype wire

### rtl/camera_bearing_to_target_top.sv
// camera_bearing_to_target_top: pipelined CORDIC atan2 bearing of a target
// relative to a camera heading, with field-of-view check.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel: drive the camera and target fields and raise start; the
//   transfer happens at each rising edge with start high and busy low. busy
//   is always low, so a new item may enter in every cycle.
//   Result channel: o_done is high for exactly one cycle with o_rel_angle
//   and o_status; the receiver takes it at the edge ending that cycle and
//   cannot hold it off.
//   Stages: each item passes one pre-rotation stage, one stage per
//   CORDIC iteration and one rounding/compare stage, in that order,
//   before its result is shown.
//   Throughput: one item per cycle, set by the fully unrolled CORDIC
//   pipeline; results leave in input order.
//   Reset (synchronous, active low) clears all stage valid bits; items in
//   flight are dropped and no result is shown for them.
//   Status: 0 ok, 1 target at camera (angle 0, no view check), 2 below
//   -fov/2, 3 above +fov/2 (checks only with check_view set).
module camera_bearing_to_target_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_BITS     = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [POS_BITS-1:0]             i_cam_x,
    input  logic signed [POS_BITS-1:0]             i_cam_y,
    input  logic signed [cbt_pkg::HEAD_W-1:0]      i_cam_heading,
    input  logic        [cbt_pkg::FOV_W-1:0]       i_field_of_view,
    input  logic signed [POS_BITS-1:0]             i_target_x,
    input  logic signed [POS_BITS-1:0]             i_target_y,
    input  logic                                   i_check_view,
    output logic                                   o_done,
    output logic signed [cbt_pkg::REL_W-1:0]       o_rel_angle,
    output cbt_pkg::t_status                       o_status
);
    import cbt_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int DW = POS_BITS + 1;
    localparam int W  = POS_BITS + CORDIC_STEPS + 3;

    logic                      r_v    [0:N];
    logic signed [W-1:0]       r_x    [0:N];
    logic signed [W-1:0]       r_y    [0:N];
    t_angle                    r_z    [0:N];
    logic signed [HEAD_W-1:0]  r_head [0:N];
    logic        [FOV_W-1:0]   r_fov  [0:N];
    logic                      r_chk  [0:N];
    logic                      r_zero [0:N];

    logic                      r_done;
    logic signed [REL_W-1:0]   r_rel;
    t_status                   r_status;

    // pre-rotation into the right half plane
    logic signed [DW-1:0] n_dx, n_dy, n_ax, n_ay;
    t_angle               n_z0;

    always_comb begin
        n_dx = DW'(i_target_x) - DW'(i_cam_x);
        n_dy = DW'(i_target_y) - DW'(i_cam_y);
        n_ax = n_dy;
        n_ay = n_dx;
        n_z0 = '0;
        if (n_dy[DW-1]) begin
            n_ax = -n_dy;
            n_ay = -n_dx;
            n_z0 = n_dx[DW-1] ? -HALF_TURN : HALF_TURN;
        end
    end

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= W'(n_ax) <<< N;
        r_y[0]    <= W'(n_ay) <<< N;
        r_z[0]    <= n_z0;
        r_head[0] <= i_cam_heading;
        r_fov[0]  <= i_field_of_view;
        r_chk[0]  <= i_check_view;
        r_zero[0] <= (n_dx == '0) && (n_dy == '0);
    end

    // one CORDIC iteration per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [W-1:0] n_xs, n_ys;
        t_angle              n_zs;

        always_comb begin
            if (!r_y[k][W-1] && (r_y[k] != '0)) begin
                n_xs = r_x[k] + (r_y[k] >>> k);
                n_ys = r_y[k] - (r_x[k] >>> k);
                n_zs = r_z[k] + ATAN_TAB[k];
            end else begin
                n_xs = r_x[k] - (r_y[k] >>> k);
                n_ys = r_y[k] + (r_x[k] >>> k);
                n_zs = r_z[k] - ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]    <= n_xs;
            r_y[k+1]    <= n_ys;
            r_z[k+1]    <= n_zs;
            r_head[k+1] <= r_head[k];
            r_fov[k+1]  <= r_fov[k];
            r_chk[k+1]  <= r_chk[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    // rounding, heading offset and view check
    t_angle                     n_zr;
    logic signed [BRG_W-1:0]    n_brg;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W:0]      n_two, n_fov;
    logic signed [REL_W-1:0]    n_rel;
    t_status                    n_status;

    always_comb begin
        n_zr   = r_z[N] + ROUND_BIAS;
        n_brg  = n_zr[ZW-1:8];
        n_sum  = SUM_W'(r_head[N]) - RIGHT_ANGLE_Q8 + SUM_W'(n_brg);
        n_two  = {n_sum, 1'b0};
        n_fov  = (SUM_W+1)'({1'b0, r_fov[N]});
        n_rel  = n_sum[REL_W-1:0];
        n_status = ST_OK;
        if (r_zero[N]) begin
            n_rel    = '0;
            n_status = ST_AT_CAM;
        end else if (r_chk[N]) begin
            if (n_two < -n_fov) begin
                n_status = ST_BELOW;
            end else if (n_two > n_fov) begin
                n_status = ST_ABOVE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel    <= n_rel;
        r_status <= n_status;
    end

    assign o_done      = r_done;
    assign o_rel_angle = r_rel;
    assign o_status    = r_status;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, N + 2))
        else $error("result strobe without a matching start transfer");

    a_at_cam_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_AT_CAM)) |-> (o_rel_angle == '0))
        else $error("target at camera with nonzero angle");

    a_no_check_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !$past(i_check_view, N + 2)) |->
            ((o_status == ST_OK) || (o_status == ST_AT_CAM)))
        else $error("view status set without view check");

    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[N] |-> !r_x[N][W-1])
        else $error("CORDIC magnitude went negative");

endmodule

`default_nettype wire
